@@ rtl/arcb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arcb_pkg: shared constants, types and helpers
// Fixed-point widths, stage counts and step functions for the arcball
// axis/angle datapath.
// ----------------------------------------------------------------------------
package arcb_pkg;

    localparam int COORD_W      = 16;
    localparam int RAD_W        = 32;
    localparam int REM_W        = RAD_W + 3;
    localparam int NUM_W        = 47;
    localparam int CX_W         = 34;
    localparam int ANG_W        = 20;
    localparam int OUT_ANG_W    = 15;

    localparam int ONE_Q14      = 16384;
    localparam int PI_Q13       = 25736;
    localparam int HALF_PI_Q16  = 102944;
    localparam int ONE_Q28      = 1 << 28;

    localparam int SQRT_STEPS   = RAD_W;
    localparam int DIV_STEPS    = 16;
    localparam int CORDIC_STEPS = 17;

    localparam int PIPE_DEPTH   = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1 + 3 + 1
                                  + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RAD_W-1:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [5:0][COORD_W-1:0] mag;
        logic [5:0]              sgn;
        logic                    deg;
    } pre_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] axis;
        logic [COORD_W-1:0]      dot;
        logic                    deg;
    } post_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] axis;
        logic                    deg;
    } side_t;

    function automatic logic [1:0] sqrt_pair(logic [RAD_W-1:0] x, int j);
        logic [1:0] p;
        p = 2'b00;
        if (j >= RAD_W / 2)
        begin
            p = x[2 * j - RAD_W +: 2];
        end
        return p;
    endfunction

    function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        sqrt_st_t         o;
        rem2  = {s.rem[REM_W-3:0], pair};
        trial = REM_W'({s.root, 2'b01});
        if (rem2 >= trial)
        begin
            o.rem  = rem2 - trial;
            o.root = {s.root[RAD_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = rem2;
            o.root = {s.root[RAD_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic signed [COORD_W-1:0] round_q14(logic signed [31:0] v);
        logic [31:0]        m;
        logic [17:0]        q;
        logic [COORD_W-1:0] qc;
        m  = v[31] ? 32'(-v) : 32'(v);
        q  = 18'((m + 32'd8192) >> 14);
        qc = (q > 18'(ONE_Q14)) ? COORD_W'(ONE_Q14) : q[COORD_W-1:0];
        return v[31] ? $signed(-qc) : $signed(qc);
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_q16(int i);
        logic signed [ANG_W-1:0] t;
        case (i)
            0:       t = ANG_W'(51472);
            1:       t = ANG_W'(30386);
            2:       t = ANG_W'(16055);
            3:       t = ANG_W'(8150);
            4:       t = ANG_W'(4091);
            5:       t = ANG_W'(2047);
            6:       t = ANG_W'(1024);
            7:       t = ANG_W'(512);
            8:       t = ANG_W'(256);
            9:       t = ANG_W'(128);
            10:      t = ANG_W'(64);
            11:      t = ANG_W'(32);
            12:      t = ANG_W'(16);
            13:      t = ANG_W'(8);
            14:      t = ANG_W'(4);
            15:      t = ANG_W'(2);
            16:      t = ANG_W'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

@@ rtl/arcb_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arcb_isqrt: pipelined integer square root
// floor(sqrt(rad * 2^32)), one root bit per stage, advancing on en.
// ----------------------------------------------------------------------------
module arcb_isqrt (
    input  logic                     clk,
    input  logic                     en,
    input  logic [arcb_pkg::RAD_W-1:0] rad,
    output logic [arcb_pkg::RAD_W-1:0] root
);
    import arcb_pkg::*;

    sqrt_st_t         st_reg  [SQRT_STEPS];
    sqrt_st_t         st_next [SQRT_STEPS];
    logic [RAD_W-1:0] rad_reg [SQRT_STEPS-1];

    always_comb
    begin
        st_next[0] = sqrt_step('0, sqrt_pair(rad, SQRT_STEPS - 1));
        for (int k = 1; k < SQRT_STEPS; k++)
        begin
            st_next[k] = sqrt_step(st_reg[k-1], sqrt_pair(rad_reg[k-1], SQRT_STEPS - 1 - k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0] <= rad;
            for (int k = 1; k < SQRT_STEPS - 1; k++)
            begin
                rad_reg[k] <= rad_reg[k-1];
            end
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign root = st_reg[SQRT_STEPS-1].root;

endmodule
`default_nettype wire

@@ rtl/arcball_rotation_axis_angle_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arcball_rotation_axis_angle_top: arcball axis and angle from two vectors
// Normalizes two Q4.12 vectors, gives their cross product in Q1.14 and the
// angle between them in Q2.13, with a flag for a zero-length vector.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_*      in         six Q4.12 coordinates, old then new
//  m_*      out        three Q1.14 axis components, Q2.13 angle; degenerate
//
//  One beat per cycle is taken, except while a held output stalls the pipe.
//  The depth is set by two 32-stage square-root pipes, a 16-stage divider
//  and a 17-stage CORDIC, each retiring one bit or one rotation per stage.
//  Reset clears the valid bits only.
//  A held output stalls the pipe only once its last stage is also full.
// ----------------------------------------------------------------------------
module arcball_rotation_axis_angle_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // old_x, old_y, old_z, new_x, new_y, new_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // axis_x, axis_y, axis_z, angle_rad, zero pad
    output logic [0:0]  m_tuser    // degenerate
);
    import arcb_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    logic                  en;
    logic                  out_load;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  m_valid_reg;
    logic [63:0]           m_data_reg;
    logic                  m_user_reg;

    assign out_load = !m_valid_reg || m_tready;
    assign en       = out_load || !vld_reg[LAST];
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
            end
            if (out_load)
            begin
                m_valid_reg <= vld_reg[LAST];
            end
        end
    end

    logic [5:0][COORD_W-1:0] in_mag;
    logic [5:0]              in_sgn;
    logic [31:0]             sq_reg [6];
    pre_t                    pre1_reg;
    logic [RAD_W-1:0]        la_reg;
    logic [RAD_W-1:0]        lb_reg;
    logic [RAD_W-1:0]        la_sum;
    logic [RAD_W-1:0]        lb_sum;
    pre_t                    pre_reg [0:SQRT_STEPS];
    logic [RAD_W-1:0]        ra;
    logic [RAD_W-1:0]        rb;

    always_comb
    begin
        for (int c = 0; c < 6; c++)
        begin
            in_sgn[c] = s_tdata[COORD_W*c + COORD_W - 1];
            in_mag[c] = in_sgn[c] ? COORD_W'(~s_tdata[COORD_W*c +: COORD_W] + 16'd1)
                                  : s_tdata[COORD_W*c +: COORD_W];
        end
        la_sum = sq_reg[0] + sq_reg[1] + sq_reg[2];
        lb_sum = sq_reg[3] + sq_reg[4] + sq_reg[5];
    end

    arcb_isqrt u_sqrt_a (.clk(clk), .en(en), .rad(la_reg), .root(ra));
    arcb_isqrt u_sqrt_b (.clk(clk), .en(en), .rad(lb_reg), .root(rb));

    logic [5:0][NUM_W-1:0] dr_reg  [0:DIV_STEPS-1];
    logic [5:0][NUM_W-1:0] dr_next [0:DIV_STEPS-2];
    logic [NUM_W-1:0]   dsub;
    logic [5:0][DIV_STEPS-1:0] dq_reg  [0:DIV_STEPS-1];
    logic [5:0][DIV_STEPS-1:0] dq_next [0:DIV_STEPS-1];
    logic [1:0][RAD_W-1:0] dv_reg [0:DIV_STEPS-1];
    logic [5:0]         dsgn_reg [0:DIV_STEPS];
    logic               ddeg_reg [0:DIV_STEPS];
    logic [5:0][NUM_W-1:0] drn_w [0:DIV_STEPS-2];
    logic               take;
    logic [DIV_STEPS-1:0] qprev;

    always_comb
    begin
        dsub  = '0;
        take  = 1'b0;
        qprev = '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int c = 0; c < 6; c++)
            begin
                dsub  = NUM_W'(dv_reg[k][(c < 3) ? 0 : 1]) << (DIV_STEPS - 1 - k);
                take  = dr_reg[k][c] >= dsub;
                qprev = (k == 0) ? '0 : dq_reg[(k == 0) ? 0 : k - 1][c];
                dq_next[k][c] = {qprev[DIV_STEPS-2:0], take};
                if (k < DIV_STEPS - 1)
                begin
                    drn_w[(k < DIV_STEPS - 1) ? k : 0][c] = take ? dr_reg[k][c] - dsub
                                                              : dr_reg[k][c];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < DIV_STEPS - 1; k++)
        begin
            dr_next[k] = drn_w[k];
        end
    end

    logic signed [COORD_W-1:0] u_reg    [6];
    logic                      udeg_reg;
    logic [5:0][COORD_W-1:0]   qclamp;
    logic signed [31:0]        prod_reg [9];
    logic                      pdeg1_reg;
    logic signed [31:0]        sum_reg  [4];
    logic                      pdeg2_reg;
    logic signed [COORD_W-1:0] rq_reg   [4];
    logic                      pdeg3_reg;
    logic signed [31:0]        dsq;
    logic [RAD_W-1:0]          v_reg;
    post_t                     post_reg [0:SQRT_STEPS];
    logic [RAD_W-1:0]          sr;

    always_comb
    begin
        for (int c = 0; c < 6; c++)
        begin
            qclamp[c] = (dq_reg[DIV_STEPS-1][c] > DIV_STEPS'(ONE_Q14))
                        ? COORD_W'(ONE_Q14) : dq_reg[DIV_STEPS-1][c];
        end
    end

    arcb_isqrt u_sqrt_d (.clk(clk), .en(en), .rad(v_reg), .root(sr));

    assign dsq = rq_reg[3] * rq_reg[3];

    logic signed [CX_W-1:0]  cx_reg  [0:CORDIC_STEPS-1];
    logic signed [CX_W-1:0]  cy_reg  [0:CORDIC_STEPS-1];
    logic signed [ANG_W-1:0] cz_reg  [0:CORDIC_STEPS];
    side_t                   cside_reg [0:CORDIC_STEPS];
    logic signed [CX_W-1:0]  cx_next [0:CORDIC_STEPS-2];
    logic signed [CX_W-1:0]  cy_next [0:CORDIC_STEPS-2];
    logic signed [ANG_W-1:0] cz_next [0:CORDIC_STEPS-1];
    logic signed [CX_W-1:0]  x0;
    logic signed [CX_W-1:0]  y0;

    always_comb
    begin
        x0 = CX_W'($signed(post_reg[SQRT_STEPS].dot)) <<< 16;
        y0 = $signed(CX_W'(sr));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!cy_reg[i][CX_W-1])
            begin
                cz_next[i] = cz_reg[i] + atan_q16(i);
            end
            else
            begin
                cz_next[i] = cz_reg[i] - atan_q16(i);
            end
        end
        for (int i = 0; i < CORDIC_STEPS - 1; i++)
        begin
            if (!cy_reg[i][CX_W-1])
            begin
                cx_next[i] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i] = cy_reg[i] - (cx_reg[i] >>> i);
            end
            else
            begin
                cx_next[i] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i] = cy_reg[i] + (cx_reg[i] >>> i);
            end
        end
    end

    logic signed [ANG_W-1:0] zr;
    logic [OUT_ANG_W-1:0]    f_ang;
    logic [OUT_ANG_W-1:0]    f_ang_reg;
    side_t                   f_side_reg;

    always_comb
    begin
        zr    = (cz_reg[CORDIC_STEPS] + ANG_W'(4)) >>> 3;
        f_ang = '0;
        if (!cz_reg[CORDIC_STEPS][ANG_W-1])
        begin
            f_ang = (zr > ANG_W'(PI_Q13)) ? OUT_ANG_W'(PI_Q13) : zr[OUT_ANG_W-1:0];
        end
        if (cside_reg[CORDIC_STEPS].deg)
        begin
            f_ang = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 6; c++)
            begin
                sq_reg[c] <= in_mag[c] * in_mag[c];
            end
            pre1_reg.mag <= in_mag;
            pre1_reg.sgn <= in_sgn;
            pre1_reg.deg <= 1'b0;

            la_reg             <= la_sum;
            lb_reg             <= lb_sum;
            pre_reg[0].mag     <= pre1_reg.mag;
            pre_reg[0].sgn     <= pre1_reg.sgn;
            pre_reg[0].deg     <= (la_sum == '0) || (lb_sum == '0);
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                pre_reg[k] <= pre_reg[k-1];
            end

            for (int c = 0; c < 6; c++)
            begin
                dr_reg[0][c] <= (NUM_W'(pre_reg[SQRT_STEPS].mag[c]) << 30)
                                + NUM_W'(((c < 3) ? ra : rb) >> 1);
            end
            dv_reg[0]   <= {rb, ra};
            dsgn_reg[0] <= pre_reg[SQRT_STEPS].sgn;
            ddeg_reg[0] <= pre_reg[SQRT_STEPS].deg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dr_reg[k] <= dr_next[k-1];
                dv_reg[k] <= dv_reg[k-1];
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dq_reg[k] <= dq_next[k];
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dsgn_reg[k] <= dsgn_reg[k-1];
                ddeg_reg[k] <= ddeg_reg[k-1];
            end

            for (int c = 0; c < 6; c++)
            begin
                u_reg[c] <= dsgn_reg[DIV_STEPS][c] ? $signed(-qclamp[c])
                                                   : $signed(qclamp[c]);
            end
            udeg_reg <= ddeg_reg[DIV_STEPS];

            prod_reg[0] <= u_reg[1] * u_reg[5];
            prod_reg[1] <= u_reg[2] * u_reg[4];
            prod_reg[2] <= u_reg[2] * u_reg[3];
            prod_reg[3] <= u_reg[0] * u_reg[5];
            prod_reg[4] <= u_reg[0] * u_reg[4];
            prod_reg[5] <= u_reg[1] * u_reg[3];
            prod_reg[6] <= u_reg[0] * u_reg[3];
            prod_reg[7] <= u_reg[1] * u_reg[4];
            prod_reg[8] <= u_reg[2] * u_reg[5];
            pdeg1_reg   <= udeg_reg;

            sum_reg[0] <= prod_reg[0] - prod_reg[1];
            sum_reg[1] <= prod_reg[2] - prod_reg[3];
            sum_reg[2] <= prod_reg[4] - prod_reg[5];
            sum_reg[3] <= prod_reg[6] + prod_reg[7] + prod_reg[8];
            pdeg2_reg  <= pdeg1_reg;

            for (int c = 0; c < 4; c++)
            begin
                rq_reg[c] <= round_q14(sum_reg[c]);
            end
            pdeg3_reg <= pdeg2_reg;

            v_reg            <= RAD_W'(ONE_Q28) - RAD_W'(dsq);
            post_reg[0].axis <= {rq_reg[2], rq_reg[1], rq_reg[0]};
            post_reg[0].dot  <= rq_reg[3];
            post_reg[0].deg  <= pdeg3_reg;
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                post_reg[k] <= post_reg[k-1];
            end

            if (x0 < 0)
            begin
                cx_reg[0] <= y0;
                cy_reg[0] <= -x0;
                cz_reg[0] <= ANG_W'(HALF_PI_Q16);
            end
            else
            begin
                cx_reg[0] <= x0;
                cy_reg[0] <= y0;
                cz_reg[0] <= '0;
            end
            cside_reg[0].axis <= post_reg[SQRT_STEPS].axis;
            cside_reg[0].deg  <= post_reg[SQRT_STEPS].deg;
            for (int i = 1; i < CORDIC_STEPS; i++)
            begin
                cx_reg[i] <= cx_next[i-1];
                cy_reg[i] <= cy_next[i-1];
            end
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                cz_reg[i]    <= cz_next[i-1];
                cside_reg[i] <= cside_reg[i-1];
            end

            f_ang_reg  <= f_ang;
            f_side_reg <= cside_reg[CORDIC_STEPS].deg ? side_t'{axis: '0, deg: 1'b1}
                                                      : cside_reg[CORDIC_STEPS];
        end
        if (out_load)
        begin
            m_data_reg <= {1'b0, f_ang_reg, f_side_reg.axis[2], f_side_reg.axis[1],
                           f_side_reg.axis[0]};
            m_user_reg <= f_side_reg.deg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && vld_reg[LAST] |-> !s_tready)
        else $error("pipe advanced over a held result");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[62:0] == '0))
        else $error("degenerate beat with nonzero payload");

    a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[62:48] <= OUT_ANG_W'(PI_Q13)))
        else $error("angle above pi");

endmodule
`default_nettype wire
